/* hdl/xepf_pkg.sv */
// Shared types, constants and codes of the X-ray event peak finder.
package xepf_pkg;

    // Default build sizes and fixed limits.
    localparam int MAX_WINDOW_DEF = 7;
    localparam int MAX_INNER_DEF  = 1024;
    localparam int MAX_OUTER      = 4096;

    // Field widths.
    localparam int VALUE_W = 24;
    localparam int OUTER_W = 12;
    localparam int HINNER_W = 10;
    localparam int CFG_W   = 24;
    localparam int POS_W   = 15;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_EVENT_SIZE = 3'd1,
        CFG_TRIM_SIZE  = 3'd2,
        CFG_OUTER_CNT  = 3'd3,
        CFG_INNER_CNT  = 3'd4,
        CFG_FRAME_BAD  = 3'd5
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_EVAL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic load;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

/* hdl/xepf_ctrl.sv */
// Controller state machine of the X-ray event peak finder.
module xepf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  xepf_pkg::sts_t sts,
    output xepf_pkg::cmd_t cmd
);
    import xepf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // A hit waits here until the output register can take it.
                if (!sts.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/xepf_datapath.sv */
// Datapath of the X-ray event peak finder: line memory, window, scan and compare.
module xepf_datapath #(
    parameter int MAX_WINDOW = xepf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_INNER  = xepf_pkg::MAX_INNER_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  xepf_pkg::cmd_t                       cmd,
    output xepf_pkg::sts_t                       sts,
    input  logic                                 cfg_write,
    input  logic [2:0]                           cfg_index,
    input  logic [xepf_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [xepf_pkg::VALUE_W-1:0]  pixel_value,
    input  logic                                 pixel_disabled,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [xepf_pkg::OUTER_W-1:0]         hit_outer,
    output logic [xepf_pkg::HINNER_W-1:0]        hit_inner,
    output logic signed [xepf_pkg::VALUE_W-1:0]  hit_value
);
    import xepf_pkg::*;

    localparam int LROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int ENT_W = VALUE_W + 1;
    localparam int IW    = $clog2(MAX_INNER);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);

    // Configuration registers.
    logic signed [VALUE_W-1:0] thr_reg;
    logic [2:0]                size_reg;
    logic [7:0]                trim_reg;
    logic [12:0]               outer_cnt_reg;
    logic [10:0]               inner_cnt_reg;
    logic                      frame_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            size_reg      <= 3'd3;
            trim_reg      <= '0;
            outer_cnt_reg <= 13'd1024;
            inner_cnt_reg <= 11'd1024;
            frame_bad_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD:  thr_reg       <= cfg_data[VALUE_W-1:0];
                CFG_EVENT_SIZE: size_reg      <= cfg_data[2:0];
                CFG_TRIM_SIZE:  trim_reg      <= cfg_data[7:0];
                CFG_OUTER_CNT:  outer_cnt_reg <= cfg_data[12:0];
                CFG_INNER_CNT:  inner_cnt_reg <= cfg_data[10:0];
                CFG_FRAME_BAD:  frame_bad_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Effective counts and window geometry.
    logic [POS_W-1:0] nx;
    logic [POS_W-1:0] ny;
    logic [WIN_W-1:0] size_eff;
    logic [WIN_W-1:0] half;
    logic [WIN_W-1:0] ext;

    always_comb
    begin
        if (outer_cnt_reg == '0)
            nx = POS_W'(1);
        else if (POS_W'(outer_cnt_reg) > POS_W'(MAX_OUTER))
            nx = POS_W'(MAX_OUTER);
        else
            nx = POS_W'(outer_cnt_reg);
        if (inner_cnt_reg == '0)
            ny = POS_W'(1);
        else if (POS_W'(inner_cnt_reg) > POS_W'(MAX_INNER))
            ny = POS_W'(MAX_INNER);
        else
            ny = POS_W'(inner_cnt_reg);
        if (size_reg == '0)
            size_eff = WIN_W'(1);
        else if (32'(size_reg) > 32'(MAX_WINDOW))
            size_eff = WIN_W'(MAX_WINDOW);
        else
            size_eff = WIN_W'(size_reg);
        half = size_eff >> 1;
        ext  = size_eff - WIN_W'(1) - half;
    end

    // Clearing pass over the line memory after reset.
    logic [IW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + IW'(1);
        end
    end

    assign sts.clear_last = (clr_reg == IW'(MAX_INNER - 1));

    // Scan position of the next item.
    logic [OUTER_W-1:0] scan_outer_reg;
    logic [IW-1:0]      scan_inner_reg;
    logic [POS_W-1:0]   inner_inc;
    logic [POS_W-1:0]   outer_inc;

    assign inner_inc = POS_W'(scan_inner_reg) + POS_W'(1);
    assign outer_inc = POS_W'(scan_outer_reg) + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_outer_reg <= '0;
            scan_inner_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (inner_inc >= ny)
            begin
                scan_inner_reg <= '0;
                if (outer_inc >= nx)
                    scan_outer_reg <= '0;
                else
                    scan_outer_reg <= outer_inc[OUTER_W-1:0];
            end
            else
            begin
                scan_inner_reg <= inner_inc[IW-1:0];
            end
        end
    end

    // Captured item and the position it was taken at.
    logic signed [VALUE_W-1:0] pix_val_reg;
    logic                      pix_dis_reg;
    logic [OUTER_W-1:0]        pos_o_reg;
    logic [IW-1:0]             pos_i_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_val_reg <= pixel_value;
            pix_dis_reg <= pixel_disabled;
        end
        if (cmd.load)
        begin
            pos_o_reg <= scan_outer_reg;
            pos_i_reg <= scan_inner_reg;
        end
    end

    // Line memory: one word per column holds the previous rows of that column.
    logic [LROWS*ENT_W-1:0] line_mem [MAX_INNER];
    logic [LROWS*ENT_W-1:0] rd_reg;
    logic [LROWS*ENT_W-1:0] wr_word;

    always_comb
    begin
        for (int r = 0; r < LROWS; r++)
        begin
            if (r == 0)
                wr_word[r*ENT_W +: ENT_W] = {pix_dis_reg, pix_val_reg};
            else
                wr_word[r*ENT_W +: ENT_W] = rd_reg[(r-1)*ENT_W +: ENT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            line_mem[clr_reg] <= '0;
        else if (cmd.load)
            line_mem[scan_inner_reg] <= wr_word;
        if (cmd.capture)
            rd_reg <= line_mem[scan_inner_reg];
    end

    // Window register: shifts one column per item.
    logic signed [VALUE_W-1:0] win_val_reg [MAX_WINDOW][MAX_WINDOW];
    logic                      win_dis_reg [MAX_WINDOW][MAX_WINDOW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_WINDOW; r++)
            begin
                for (int k = 0; k < MAX_WINDOW; k++)
                begin
                    win_val_reg[r][k] <= '0;
                    win_dis_reg[r][k] <= 1'b0;
                end
            end
        end
        else if (cmd.load)
        begin
            for (int r = 0; r < MAX_WINDOW; r++)
            begin
                for (int k = 1; k < MAX_WINDOW; k++)
                begin
                    win_val_reg[r][k] <= win_val_reg[r][k-1];
                    win_dis_reg[r][k] <= win_dis_reg[r][k-1];
                end
            end
            win_val_reg[0][0] <= pix_val_reg;
            win_dis_reg[0][0] <= pix_dis_reg;
            for (int r = 1; r < MAX_WINDOW; r++)
            begin
                win_val_reg[r][0] <= rd_reg[(r-1)*ENT_W +: VALUE_W];
                win_dis_reg[r][0] <= rd_reg[(r-1)*ENT_W + VALUE_W];
            end
        end
    end

    // Margin test and parallel window compare.
    logic signed [POS_W-1:0]   co;
    logic signed [POS_W-1:0]   ci;
    logic signed [POS_W-1:0]   margin;
    logic signed [VALUE_W-1:0] center;
    logic                      in_margin;
    logic                      win_ok;
    logic                      in_win;
    logic                      is_center;
    logic                      hit_now;

    always_comb
    begin
        co     = signed'(POS_W'(pos_o_reg)) - signed'(POS_W'(ext));
        ci     = signed'(POS_W'(pos_i_reg)) - signed'(POS_W'(ext));
        margin = signed'(POS_W'(half)) + signed'(POS_W'(trim_reg));
        in_margin = (co >= margin) && (co < signed'(nx) - margin) &&
                    (ci >= margin) && (ci < signed'(ny) - margin);
        center = '0;
        for (int r = 0; r < MAX_WINDOW; r++)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                if (WIN_W'(r) == ext && WIN_W'(k) == ext)
                    center = win_val_reg[r][k];
            end
        end
        win_ok = (center >= thr_reg);
        in_win    = 1'b0;
        is_center = 1'b0;
        for (int r = 0; r < MAX_WINDOW; r++)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                in_win    = (WIN_W'(r) < size_eff) && (WIN_W'(k) < size_eff);
                is_center = (WIN_W'(r) == ext) && (WIN_W'(k) == ext);
                if (in_win && win_dis_reg[r][k])
                    win_ok = 1'b0;
                if (in_win && !is_center && (win_val_reg[r][k] >= center))
                    win_ok = 1'b0;
            end
        end
        hit_now = !frame_bad_reg && in_margin && win_ok;
    end

    assign sts.hit = hit_now;

    // Output register.
    logic out_valid_reg;

    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hit_outer <= co[OUTER_W-1:0];
            hit_inner <= ci[HINNER_W-1:0];
            hit_value <= center;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/xray_event_peak_finder_top.sv */
// Top level of the X-ray event peak finder.
//
// Finds local maxima in a streamed frame: each pixel item goes in turn through
// accept and line-memory read, window shift and line-memory update, and
// parallel window compare, and no new item is taken until the compare of the
// last one is done; the compare step holds longer only while a hit waits on
// a stalled, full output register. The line memory keeps one word per column
// with the last MAX_WINDOW-1 rows. After reset a clearing pass writes zero to
// each of the MAX_INNER memory words, one per cycle, and no item is taken
// until it ends; configuration writes are taken at any time.
module xray_event_peak_finder_top #(
    parameter int MAX_WINDOW = xepf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_INNER  = xepf_pkg::MAX_INNER_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [2:0]                           cfg_index,
    input  logic [xepf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [xepf_pkg::VALUE_W-1:0]  pixel_value,
    input  logic                                 pixel_disabled,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [xepf_pkg::OUTER_W-1:0]         hit_outer,
    output logic [xepf_pkg::HINNER_W-1:0]        hit_inner,
    output logic signed [xepf_pkg::VALUE_W-1:0]  hit_value
);
    import xepf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    xepf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Line memory, window and compare.
    xepf_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_INNER  (MAX_INNER)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_value    (pixel_value),
        .pixel_disabled (pixel_disabled),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_outer      (hit_outer),
        .hit_inner      (hit_inner),
        .hit_value      (hit_value)
    );

endmodule
